// ===== sv/dpq_pkg.sv =====
// shared types, codes and helpers for the double-ended priority queue
`default_nettype none

package dpq_pkg;

    localparam int KEY_W        = 32;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
    } t_lane;

    typedef struct packed {
        logic                    ins;
        logic                    pop_max;
        logic                    pop_min;
        logic                    clr;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic                    empty;
        logic signed [KEY_W-1:0] max_key;
        logic signed [KEY_W-1:0] min_key;
    } t_head;

    localparam logic signed [KEY_W-1:0] KEY_LOWEST  = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_HIGHEST = {1'b0, {(KEY_W-1){1'b1}}};

    localparam t_lane LANE_NONE = '{valid: 1'b0, key: '0};

    // true when a has to sit further from the head than b
    function automatic logic f_after(input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b,
                                     input logic                    desc);
        return desc ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

// ===== sv/dpq_if.sv =====
// request and response channel interfaces
`default_nettype none

interface dpq_in_if import dpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_op                     operation;
    logic signed [KEY_W-1:0] key_value;

    modport source(output valid, output operation, output key_value, input ready);
    modport sink(input valid, input operation, input key_value, output ready);
endinterface

interface dpq_out_if import dpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    is_empty;
    logic signed [KEY_W-1:0] largest_key;
    logic signed [KEY_W-1:0] smallest_key;
    logic [1:0]              status_code;

    modport source(output valid, output is_empty, output largest_key,
                   output smallest_key, output status_code, input ready);
    modport sink(input valid, input is_empty, input largest_key,
                 input smallest_key, input status_code, output ready);
endinterface

`default_nettype wire

// ===== sv/dpq_cell.sv =====
// one cell of the sorted chain, holding one ascending and one descending slot
`default_nettype none

module dpq_cell import dpq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_lane i_asc_prev,
    input  wire t_lane i_asc_next,
    input  wire t_lane i_desc_prev,
    input  wire t_lane i_desc_next,
    output t_lane      o_asc,
    output t_lane      o_desc
);

    t_lane r_asc;
    t_lane n_asc;
    t_lane r_desc;
    t_lane n_desc;

    function automatic t_lane f_lane_next(input t_lane self,
                                          input t_lane prev,
                                          input t_lane next,
                                          input t_cmd  cmd,
                                          input logic  desc,
                                          input logic  pop_front,
                                          input logic  drop_back);
        t_lane res;
        logic  prev_after;
        logic  self_after;
        logic  take;
        res        = self;
        prev_after = prev.valid && f_after(prev.key, cmd.key, desc);
        self_after = !self.valid || f_after(self.key, cmd.key, desc);
        take       = prev.valid && !prev_after && self_after;
        if (cmd.clr) begin
            res.valid = 1'b0;
        end else if (cmd.ins) begin
            if (prev_after) begin
                res = prev;
            end else if (take) begin
                res = '{valid: 1'b1, key: cmd.key};
            end
        end else if (pop_front) begin
            res = next;
        end else if (drop_back) begin
            res.valid = self.valid && next.valid;
        end
        return res;
    endfunction

    always_comb begin
        n_asc  = f_lane_next(r_asc, i_asc_prev, i_asc_next, i_cmd, 1'b0,
                             i_cmd.pop_min, i_cmd.pop_max);
        n_desc = f_lane_next(r_desc, i_desc_prev, i_desc_next, i_cmd, 1'b1,
                             i_cmd.pop_max, i_cmd.pop_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asc.valid  <= 1'b0;
            r_desc.valid <= 1'b0;
        end else begin
            r_asc.valid  <= n_asc.valid;
            r_desc.valid <= n_desc.valid;
        end
        r_asc.key  <= n_asc.key;
        r_desc.key <= n_desc.key;
    end

    assign o_asc  = r_asc;
    assign o_desc = r_desc;

endmodule

`default_nettype wire

// ===== sv/dpq_ctrl.sv =====
// sequencer: request decode, id counter, status and result register
`default_nettype none

module dpq_ctrl import dpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dpq_in_if.sink     i_req,
    dpq_out_if.source  o_rsp,
    input  wire t_head i_head,
    output t_cmd       o_cmd
);

    localparam int              ID_W    = $clog2(CAPACITY + 1);
    localparam logic [ID_W-1:0] ID_FULL = ID_W'(CAPACITY);

    t_state                  r_state;
    t_state                  n_state;
    logic [ID_W-1:0]         r_id;
    logic [ID_W-1:0]         n_id;
    t_status                 r_status;
    t_status                 n_status;
    t_status                 r_pend_status;
    logic                    r_out_valid;
    logic                    r_out_empty;
    logic signed [KEY_W-1:0] r_out_max;
    logic signed [KEY_W-1:0] r_out_min;
    logic                    w_ready;
    logic                    w_accept;
    logic                    w_load;
    logic                    w_full;

    assign w_full   = (r_id == ID_FULL);
    assign w_accept = i_req.valid && w_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ready = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE:  w_ready = 1'b1;
            S_LOAD:  w_load  = !r_out_valid || o_rsp.ready;
            default: w_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_status = ST_DONE;
        case (i_req.operation)
            OP_INSERT:  n_status = w_full ? ST_FULL : ST_DONE;
            OP_DEL_MAX: n_status = i_head.empty ? ST_EMPTY : ST_DONE;
            OP_DEL_MIN: n_status = i_head.empty ? ST_EMPTY : ST_DONE;
            OP_CLEAR:   n_status = ST_DONE;
            default:    n_status = ST_DONE;
        endcase
    end

    always_comb begin
        o_cmd.ins     = w_accept && (i_req.operation == OP_INSERT) && !w_full;
        o_cmd.pop_max = w_accept && (i_req.operation == OP_DEL_MAX);
        o_cmd.pop_min = w_accept && (i_req.operation == OP_DEL_MIN);
        o_cmd.clr     = w_accept && (i_req.operation == OP_CLEAR);
        o_cmd.key     = i_req.key_value;
    end

    always_comb begin
        n_id = r_id;
        if (o_cmd.clr) begin
            n_id = '0;
        end else if (o_cmd.ins) begin
            n_id = r_id + ID_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_id        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_id    <= n_id;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status waits here while an earlier result is still held
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_status;
        end
        if (w_load) begin
            r_status    <= r_pend_status;
            r_out_empty <= i_head.empty;
            r_out_max   <= i_head.empty ? '0 : i_head.max_key;
            r_out_min   <= i_head.empty ? '0 : i_head.min_key;
        end
    end

    assign i_req.ready        = w_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.is_empty     = r_out_empty;
    assign o_rsp.largest_key  = r_out_max;
    assign o_rsp.smallest_key = r_out_min;
    assign o_rsp.status_code  = r_status;

    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id <= ID_FULL)
        else $error("entry id counter beyond capacity");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.operation == OP_INSERT) && w_full) |=>
            (r_pend_status == ST_FULL) && (r_id == ID_FULL))
        else $error("insert at full capacity not refused");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_empty) |->
            (o_rsp.largest_key == '0) && (o_rsp.smallest_key == '0))
        else $error("empty result carries non-zero keys");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_ready)
        else $error("second request taken before result loaded");

endmodule

`default_nettype wire

// ===== sv/double_ended_priority_queue.sv =====
// double-ended priority queue top level: sequencer plus a chain of sorting cells
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------------
//  i_req    | in  | valid / ready    | operation, key_value
//  o_rsp    | out | valid / ready    | is_empty, largest_key, smallest_key, status_code
//
//  an item updates every cell of the chain at once on the edge that accepts it;
//  the chain heads are then loaded into the result register once it is free
//  reset clears the cell valid bits and the id counter
//  a result held by o_rsp does not block one further transfer on i_req;
//  that item then waits in the chain until the result register frees up
`default_nettype none

module double_ended_priority_queue import dpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpq_in_if.sink    i_req,
    dpq_out_if.source o_rsp
);

    t_cmd  w_cmd;
    t_head w_head;
    t_lane w_asc  [CAPACITY+2];
    t_lane w_desc [CAPACITY+2];

    // chain ends: sentinels that never move the head and never feed the tail
    assign w_asc[0]           = '{valid: 1'b1, key: KEY_LOWEST};
    assign w_desc[0]          = '{valid: 1'b1, key: KEY_HIGHEST};
    assign w_asc[CAPACITY+1]  = LANE_NONE;
    assign w_desc[CAPACITY+1] = LANE_NONE;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dpq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_asc_prev  (w_asc[g]),
            .i_asc_next  (w_asc[g+2]),
            .i_desc_prev (w_desc[g]),
            .i_desc_next (w_desc[g+2]),
            .o_asc       (w_asc[g+1]),
            .o_desc      (w_desc[g+1])
        );
    end

    assign w_head.empty   = !w_asc[1].valid;
    assign w_head.max_key = w_desc[1].key;
    assign w_head.min_key = w_asc[1].key;

    dpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_head  (w_head),
        .o_cmd   (w_cmd)
    );

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_asc[1].valid == w_desc[1].valid)
        else $error("ascending and descending lanes disagree on emptiness");

    a_asc_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_asc[2].valid |-> ($signed(w_asc[2].key) >= $signed(w_asc[1].key)))
        else $error("ascending lane out of order at its head");

    a_heads_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_asc[1].valid |-> ($signed(w_desc[1].key) >= $signed(w_asc[1].key)))
        else $error("largest key below smallest key");

endmodule

`default_nettype wire
